[rtl/core/min_edges_strong_connectivity_defines.svh]
// Assertion macros for the strong connectivity block.
// Used by min_edges_strong_connectivity.sv; depends on clk and rst_n in scope.
`ifndef MIN_EDGES_STRONG_CONNECTIVITY_DEFINES_SVH
`define MIN_EDGES_STRONG_CONNECTIVITY_DEFINES_SVH

// Same-cycle implication, held off during reset
`define MESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define MESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mesc_pkg.sv]
// Shared types, constants and helpers for the strong connectivity block.
// No dependencies.
package mesc_pkg;

  localparam int VERTICES = 32;
  localparam int VW       = $clog2(VERTICES);  // vertex index width
  localparam int CW       = VW + 1;            // count width, holds VERTICES

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [VERTICES-1:0] vmask_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_P1,
    S_P2_ROOT,
    S_P2_WALK,
    S_DONE
  } state_t;

  // Lowest set bit of a vertex mask
  function automatic logic [VW-1:0] first_one(input vmask_t vec);
    logic [VW-1:0] idx;
    idx = '0;
    for (int k = VERTICES - 1; k >= 0; k--) begin
      if (vec[k]) idx = VW'(k);
    end
    return idx;
  endfunction

endpackage

[rtl/core/min_edges_strong_connectivity.sv]
// Top level of the strong connectivity block: adjacency stores, DFS sequencer.
// Depends on mesc_pkg and min_edges_strong_connectivity_defines.svh.

// Edge beats (op = 0) are stored in a forward and a reverse bit-matrix;
// edges naming a vertex at or above the active count (vertex_count, taken
// as 1 when zero and as VERTICES above it) are dropped. A query beat
// (op = 1) runs Kosaraju's algorithm and returns one result beat:
// edges_needed and component_count. The query is paced by the single
// find-first unit, which advances the depth-first walk by one push or pop
// per cycle; the result then waits while a previous result is still held
// by out_stall. in_stall is high for the whole query; a finished result can
// wait on out_stall while the next edge beats are taken. vertex_count may
// be written only while the block is idle. The graph stays until reset.
module min_edges_strong_connectivity (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [5:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [mesc_pkg::VW-1:0] in_src_vertex,
  input  logic [mesc_pkg::VW-1:0] in_dst_vertex,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [mesc_pkg::CW-1:0] out_edges_needed,
  output logic [mesc_pkg::CW-1:0] out_component_count
);
  import mesc_pkg::*;
  `include "min_edges_strong_connectivity_defines.svh"

  // Control and datapath registers
  state_t          state_r, state_nxt;
  logic [5:0]      vcount_r;
  vmask_t          fwd_r [VERTICES];
  vmask_t          rev_r [VERTICES];
  logic [VW-1:0]   stack_r [VERTICES];
  logic [VW-1:0]   finish_r [VERTICES];
  vmask_t          vis_r, vis_nxt;
  vmask_t          memb_r, memb_nxt;
  vmask_t          facc_r, facc_nxt;
  vmask_t          racc_r, racc_nxt;
  logic [CW-1:0]   sp_r, sp_nxt;
  logic [CW-1:0]   done_r, done_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   comps_r, comps_nxt;
  logic [CW-1:0]   srcs_r, srcs_nxt;
  logic [CW-1:0]   sinks_r, sinks_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   edges_r, edges_nxt;
  logic [CW-1:0]   ccount_r, ccount_nxt;

  // Write strobes for the stack and finish lists
  logic            push_we, fin_we;
  logic [VW-1:0]   push_addr, push_data, fin_addr, fin_data;

  logic [CW-1:0]   n_eff;
  vmask_t          act;
  logic [VW-1:0]   top_idx, top_v, fin_rd;
  vmask_t          scan_vec, pick_oh, one_v;
  logic            hit, in_x, out_x, edge_ok, in_acc, out_acc;
  logic [VW-1:0]   pick;

  // Active vertex count and mask
  always_comb begin
    if (vcount_r == '0) n_eff = CW'(1);
    else if (vcount_r > 6'(VERTICES)) n_eff = CW'(VERTICES);
    else n_eff = CW'(vcount_r);
    for (int k = 0; k < VERTICES; k++) begin
      act[k] = (CW'(k) < n_eff);
    end
  end

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign edge_ok = (CW'(in_src_vertex) < n_eff) && (CW'(in_dst_vertex) < n_eff);

  // Shared find-first unit
  assign top_idx = VW'(sp_r - CW'(1));
  assign top_v   = stack_r[top_idx];
  assign fin_rd  = finish_r[VW'(idx_r - CW'(1))];
  assign one_v   = {{(VERTICES-1){1'b0}}, 1'b1};

  always_comb begin
    if (state_r == S_P1) begin
      scan_vec = (sp_r == '0) ? (~vis_r & act) : (fwd_r[top_v] & ~vis_r & act);
    end else begin
      scan_vec = rev_r[top_v] & ~vis_r & act;
    end
  end

  assign hit     = |scan_vec;
  assign pick    = first_one(scan_vec);
  assign pick_oh = one_v << pick;
  assign out_x   = |(facc_r & act & ~memb_r);
  assign in_x    = |(racc_r & act & ~memb_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_op == OP_QUERY) state_nxt = S_P1;
      end
      S_P1: begin
        if (sp_r == '0 && !hit) state_nxt = S_P2_ROOT;
      end
      S_P2_ROOT: begin
        if (idx_r == '0) state_nxt = S_DONE;
        else if (!vis_r[fin_rd]) state_nxt = S_P2_WALK;
      end
      S_P2_WALK: begin
        if (sp_r == '0) state_nxt = S_P2_ROOT;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    vis_nxt       = vis_r;
    memb_nxt      = memb_r;
    facc_nxt      = facc_r;
    racc_nxt      = racc_r;
    sp_nxt        = sp_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    comps_nxt     = comps_r;
    srcs_nxt      = srcs_r;
    sinks_nxt     = sinks_r;
    edges_nxt     = edges_r;
    ccount_nxt    = ccount_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    push_we       = 1'b0;
    push_addr     = VW'(sp_r);
    push_data     = pick;
    fin_we        = 1'b0;
    fin_addr      = VW'(done_r);
    fin_data      = top_v;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_op == OP_QUERY) begin
          vis_nxt   = '0;
          sp_nxt    = '0;
          done_nxt  = '0;
          comps_nxt = '0;
          srcs_nxt  = '0;
          sinks_nxt = '0;
        end
      end
      S_P1: begin
        if (hit) begin
          // descend into the lowest unvisited neighbor, or a new root
          vis_nxt = vis_r | pick_oh;
          push_we = 1'b1;
          sp_nxt  = sp_r + CW'(1);
        end else if (sp_r != '0) begin
          // vertex finished
          fin_we   = 1'b1;
          done_nxt = done_r + CW'(1);
          sp_nxt   = sp_r - CW'(1);
        end else begin
          vis_nxt = '0;
          idx_nxt = done_r;
        end
      end
      S_P2_ROOT: begin
        if (idx_r != '0) begin
          idx_nxt = idx_r - CW'(1);
          if (!vis_r[fin_rd]) begin
            vis_nxt   = vis_r | (one_v << fin_rd);
            memb_nxt  = one_v << fin_rd;
            facc_nxt  = '0;
            racc_nxt  = '0;
            push_we   = 1'b1;
            push_addr = '0;
            push_data = fin_rd;
            sp_nxt    = CW'(1);
          end
        end
      end
      S_P2_WALK: begin
        if (sp_r == '0) begin
          // component closed: classify by cross edges
          comps_nxt = comps_r + CW'(1);
          if (!in_x) srcs_nxt = srcs_r + CW'(1);
          if (!out_x) sinks_nxt = sinks_r + CW'(1);
        end else if (hit) begin
          vis_nxt  = vis_r | pick_oh;
          memb_nxt = memb_r | pick_oh;
          push_we  = 1'b1;
          sp_nxt   = sp_r + CW'(1);
        end else begin
          facc_nxt = facc_r | fwd_r[top_v];
          racc_nxt = racc_r | rev_r[top_v];
          sp_nxt   = sp_r - CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          ccount_nxt    = comps_r;
          if (comps_r > CW'(1)) edges_nxt = (srcs_r > sinks_r) ? srcs_r : sinks_r;
          else edges_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall            = (state_r != S_IDLE);
  assign cfg_ready           = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_edges_needed    = edges_r;
  assign out_component_count = ccount_r;

  // Control registers and adjacency matrices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= 6'(VERTICES);
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      for (int k = 0; k < VERTICES; k++) begin
        fwd_r[k] <= '0;
        rev_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sp_r        <= sp_nxt;
      if (cfg_valid && cfg_ready) vcount_r <= cfg_data;
      if (state_r == S_IDLE && in_acc && in_op == OP_ADD && edge_ok) begin
        fwd_r[in_src_vertex][in_dst_vertex] <= 1'b1;
        rev_r[in_dst_vertex][in_src_vertex] <= 1'b1;
      end
    end
  end

  // Walk payload registers
  always_ff @(posedge clk) begin
    vis_r    <= vis_nxt;
    memb_r   <= memb_nxt;
    facc_r   <= facc_nxt;
    racc_r   <= racc_nxt;
    done_r   <= done_nxt;
    idx_r    <= idx_nxt;
    comps_r  <= comps_nxt;
    srcs_r   <= srcs_nxt;
    sinks_r  <= sinks_nxt;
    edges_r  <= edges_nxt;
    ccount_r <= ccount_nxt;
    if (push_we) stack_r[push_addr] <= push_data;
    if (fin_we) finish_r[fin_addr] <= fin_data;
  end

  // Checks
  `MESC_ASSERT_NOW(a_sp_bound, 1'b1, sp_r <= CW'(VERTICES), "walk stack overflow")
  `MESC_ASSERT_NEXT(a_all_finished, state_r == S_P1 && state_nxt == S_P2_ROOT, done_r == n_eff, "first pass missed vertices")
  `MESC_ASSERT_NOW(a_comp_range, state_r == S_DONE, comps_r != '0 && comps_r <= done_r, "component count out of range")

endmodule
